// File: hw/rtl/lmps_pkg.sv
// ----------------------------------------------------------------------------
// lmps_pkg: shared constants and helpers for the LED matrix PWM scanner
// Matrix geometry, frame store layout, action and buffer state codes.
// ----------------------------------------------------------------------------
package lmps_pkg;

  // Matrix geometry
  localparam int ROWS    = 8;
  localparam int LEVELS  = 16;
  localparam int BUFFERS = 3;

  // Frame store layout: 3 colors x 32 bytes per buffer
  localparam int BUF_BYTES = 96;
  localparam int MEM_DEPTH = BUFFERS * BUF_BYTES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // Derived widths
  localparam int ROW_W  = $clog2(ROWS);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int BUF_W  = $clog2(BUFFERS);
  localparam int FRAME_TICKS = ROWS * LEVELS;
  localparam int FC_W   = $clog2(FRAME_TICKS);
  localparam int PACK_N = (BUFFERS < 3) ? BUFFERS : 3;

  localparam logic [2:0] BUF_LIMIT = 3'(BUFFERS);

  // Request actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_STATE = 2'd2;

  // Buffer states
  localparam logic [1:0] ST_CLEAN = 2'd0;
  localparam logic [1:0] ST_BUSY  = 2'd1;
  localparam logic [1:0] ST_FRAME = 2'd2;
  localparam logic [1:0] ST_CMD   = 2'd3;

  // Tick periods and the levels where they change
  localparam logic [8:0] PERIOD_SHORT = 9'd100;
  localparam logic [8:0] PERIOD_MID   = 9'd200;
  localparam logic [8:0] PERIOD_LONG  = 9'd300;
  localparam logic [3:0] LVL_MID      = 4'd6;
  localparam logic [3:0] LVL_LONG     = 4'd11;

  localparam logic [6:0] OFF_LIMIT = 7'(BUF_BYTES);
  localparam logic [3:0] NIB_MASK  = 4'hf;

  // Start address of a buffer in the frame store (times 96)
  function automatic logic [MEM_AW-1:0] buf_base(input logic [BUF_W-1:0] b);
    logic [MEM_AW-1:0] w;
    w = MEM_AW'(b);
    return (w << 6) + (w << 5);
  endfunction

  // Cyclic step to the following buffer
  function automatic logic [BUF_W-1:0] step_buf(input logic [BUF_W-1:0] b);
    return (b == BUF_W'(BUFFERS - 1)) ? '0 : b + 1'b1;
  endfunction

endpackage

// File: hw/rtl/lmps_if.sv
// ----------------------------------------------------------------------------
// lmps_if: request, result and configuration channels of the scanner
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface lmps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [1:0] buffer_sel;
  logic [6:0] byte_addr;
  logic [7:0] byte_data;
  logic [1:0] new_state;

  modport source (output valid, action, buffer_sel, byte_addr, byte_data, new_state,
                  input ready);
  modport sink   (input valid, action, buffer_sel, byte_addr, byte_data, new_state,
                  output ready);
endinterface

interface lmps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  row_select;
  logic [23:0] column_bits;
  logic [8:0]  tick_period;
  logic [1:0]  shown_buffer;
  logic        frame_done;
  logic [5:0]  buffer_states;

  modport source (output valid, row_select, column_bits, tick_period, shown_buffer,
                  frame_done, buffer_states, input ready);
  modport sink   (input valid, row_select, column_bits, tick_period, shown_buffer,
                  frame_done, buffer_states, output ready);
endinterface

interface lmps_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/led_matrix_pwm_scanner.sv
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner: row-scan software PWM for an RGB LED matrix
// Interlaced row scan over three frame buffers with level-stepped periods.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  --------+-----+-------------+--------------------------------------------
//  in_i    | in  | valid/ready | action, buffer_sel, byte_addr, byte_data,
//          |     |             | new_state
//  out_o   | out | valid/ready | row_select, column_bits, tick_period,
//          |     |             | shown_buffer, frame_done, buffer_states
//  cfg_i   | in  | valid/ready | data (auto_next), always ready
//
//  A scan tick has the accept step, then 12 frame-store reads on the single
//  read port with two column bits shifted in per read, and one drain step
//  for the last read. After reset the frame store is zeroed one byte a
//  cycle; in_i is not ready during that pass. A tick waits while a result
//  is still held in the output register; writes wait for the same slot.
// ----------------------------------------------------------------------------
module led_matrix_pwm_scanner (
  input  logic              clk_i,
  input  logic              rst_ni,
  lmps_in_if.sink           in_i,
  lmps_out_if.source        out_o,
  lmps_cfg_if.sink          cfg_i
);
  import lmps_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_BUILD
  } state_e;

  state_e               state_q;
  logic [MEM_AW-1:0]    clr_cnt_q;
  logic [3:0]           cnt_q;
  logic                 rd_vld_q;
  logic                 rd_oob_q;
  logic [7:0]           rd_data_q;
  logic [7:0]           mem_q [MEM_DEPTH];

  logic [ROW_W-1:0]     row_q, row_d;
  logic [LVL_W-1:0]     lvl_q, lvl_d;
  logic [FC_W-1:0]      fc_q, fc_d;
  logic [BUF_W-1:0]     cur_q, cur_d;
  logic [BUF_W-1:0]     nxt_q, nxt_d;
  logic [1:0]           st_q [BUFFERS];
  logic [1:0]           st_d [BUFFERS];
  logic [23:0]          pend_q;
  logic [8:0]           period_q, period_d;
  logic                 auto_q;

  logic                 out_vld_q;
  logic [7:0]           o_row_q;
  logic [23:0]          o_cols_q;
  logic [8:0]           o_period_q;
  logic [1:0]           o_buf_q;
  logic                 o_done_q;
  logic [5:0]           o_states_q;

  logic                 in_rdy;
  logic                 in_acc;
  logic                 tick_acc;
  logic                 wr_acc;
  logic                 stset_acc;
  logic                 sel_ok;
  logic                 done;
  logic [ROW_W:0]       row_sum;
  logic [LVL_W-1:0]     lvl_nx;
  logic [3:0]           lvl4_nx;
  logic                 stop;
  logic [7:0]           row_onehot;
  logic [5:0]           states_pack;

  logic                 mem_we;
  logic [MEM_AW-1:0]    mem_waddr;
  logic [7:0]           mem_wdata;
  logic [6:0]           rd_off;
  logic                 rd_oob;
  logic [MEM_AW-1:0]    rd_addr;
  logic [7:0]           rd_byte;
  logic [3:0]           lvl4;

  // Handshake
  assign in_rdy    = (state_q == S_IDLE) && (!out_vld_q || out_o.ready);
  assign in_i.ready = in_rdy;
  assign cfg_i.ready = 1'b1;
  assign in_acc    = in_i.valid && in_rdy;
  assign sel_ok    = {1'b0, in_i.buffer_sel} < BUF_LIMIT;
  assign tick_acc  = in_acc && (in_i.action == ACT_TICK);
  assign wr_acc    = in_acc && (in_i.action == ACT_WRITE) && sel_ok &&
                     (in_i.byte_addr < OFF_LIMIT);
  assign stset_acc = in_acc && (in_i.action == ACT_STATE) && sel_ok;

  // Tick state update: row, level, frame, buffer swap, search
  always_comb begin
    row_d    = row_q;
    lvl_d    = lvl_q;
    period_d = period_q;
    row_sum  = {1'b0, row_q} + (ROW_W + 1)'(2);
    lvl_nx   = (lvl_q == LVL_W'(LEVELS - 1)) ? '0 : lvl_q + 1'b1;
    lvl4_nx  = 4'(lvl_nx);
    if (row_sum == (ROW_W + 1)'(ROWS)) begin
      row_d = ROW_W'(1);
    end else if (row_sum > (ROW_W + 1)'(ROWS)) begin
      row_d = '0;
      lvl_d = lvl_nx;
      if (lvl4_nx < LVL_MID) begin
        period_d = PERIOD_SHORT;
      end else if (lvl4_nx < LVL_LONG) begin
        period_d = PERIOD_MID;
      end else begin
        period_d = PERIOD_LONG;
      end
    end else begin
      row_d = row_sum[ROW_W-1:0];
    end

    done  = (fc_q == FC_W'(FRAME_TICKS - 1));
    fc_d  = done ? '0 : fc_q + 1'b1;
    st_d  = st_q;
    cur_d = cur_q;
    if (done) begin
      st_d[cur_q] = ST_CLEAN;
      st_d[nxt_q] = ST_BUSY;
      cur_d       = nxt_q;
    end
    for (int i = 0; i < BUFFERS; i++) begin
      if (st_d[i] == ST_CMD) st_d[i] = ST_CLEAN;
    end

    // next ready buffer after the current one
    nxt_d = nxt_q;
    stop  = 1'b0;
    if (auto_q && (nxt_q == cur_d)) begin
      nxt_d = step_buf(nxt_q);
      for (int n = 0; n < BUFFERS; n++) begin
        if (!stop) begin
          if ((nxt_d == cur_d) || (st_d[nxt_d] == ST_FRAME)) begin
            stop = 1'b1;
          end else begin
            nxt_d = step_buf(nxt_d);
          end
        end
      end
    end

    for (int i = 0; i < 8; i++) begin
      row_onehot[i] = (int'(row_q) == i);
    end
    states_pack = '0;
    for (int i = 0; i < PACK_N; i++) begin
      states_pack[2*i +: 2] = st_d[i];
    end
  end

  // Frame store ports: clearing pass or host write, one read for the build
  assign mem_we    = (state_q == S_CLEAR) || wr_acc;
  assign mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q :
                     buf_base(in_i.buffer_sel[BUF_W-1:0]) + MEM_AW'(in_i.byte_addr);
  assign mem_wdata = (state_q == S_CLEAR) ? 8'h00 : in_i.byte_data;
  assign rd_off    = {cnt_q[3:2], 5'b0} + 7'({row_q, 2'b00}) + 7'(cnt_q[1:0]);
  assign rd_oob    = rd_off >= OFF_LIMIT;
  assign rd_addr   = rd_oob ? '0 : buf_base(cur_q) + MEM_AW'(rd_off);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_data_q <= mem_q[rd_addr];
  end

  // Column nibble compare on the byte read last cycle
  assign rd_byte = rd_oob_q ? 8'h00 : rd_data_q;
  assign lvl4    = 4'(lvl_q);

  // Sequencer, scan state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_cnt_q  <= '0;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      rd_oob_q   <= 1'b0;
      row_q      <= '0;
      lvl_q      <= '0;
      fc_q       <= '0;
      cur_q      <= '0;
      nxt_q      <= BUF_W'(1);
      for (int i = 0; i < BUFFERS; i++) st_q[i] <= ST_FRAME;
      pend_q     <= '0;
      period_q   <= PERIOD_MID;
      auto_q     <= 1'b1;
      out_vld_q  <= 1'b0;
      o_row_q    <= '0;
      o_cols_q   <= '0;
      o_period_q <= '0;
      o_buf_q    <= '0;
      o_done_q   <= 1'b0;
      o_states_q <= '0;
    end else begin
      if (cfg_i.valid) auto_q <= cfg_i.data;

      // result slot: a new tick fills it, the sink empties it
      if (tick_acc) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (stset_acc) st_q[in_i.buffer_sel[BUF_W-1:0]] <= in_i.new_state;
          if (tick_acc) begin
            o_row_q    <= row_onehot;
            o_cols_q   <= pend_q;
            o_period_q <= period_d;
            o_buf_q    <= 2'(cur_d);
            o_done_q   <= done;
            o_states_q <= states_pack;
            row_q      <= row_d;
            lvl_q      <= lvl_d;
            period_q   <= period_d;
            fc_q       <= fc_d;
            cur_q      <= cur_d;
            nxt_q      <= nxt_d;
            st_q       <= st_d;
            cnt_q      <= '0;
            rd_vld_q   <= 1'b0;
            state_q    <= S_BUILD;
          end
        end
        S_BUILD: begin
          // issue read cnt_q, consume read cnt_q - 1
          rd_vld_q <= (cnt_q < 4'd12);
          rd_oob_q <= rd_oob;
          if (cnt_q < 4'd12) cnt_q <= cnt_q + 1'b1;
          if (rd_vld_q) begin
            pend_q <= {pend_q[21:0], (rd_byte[7:4] > lvl4),
                       ((rd_byte[3:0] & NIB_MASK) > lvl4)};
          end
          if (cnt_q == 4'd12) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result channel
  assign out_o.valid         = out_vld_q;
  assign out_o.row_select    = o_row_q;
  assign out_o.column_bits   = o_cols_q;
  assign out_o.tick_period   = o_period_q;
  assign out_o.shown_buffer  = o_buf_q;
  assign out_o.frame_done    = o_done_q;
  assign out_o.buffer_states = o_states_q;

endmodule

// File: hw/rtl/lmps_checker.sv
// ----------------------------------------------------------------------------
// lmps_checker: port-level checks for the LED matrix PWM scanner
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module lmps_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  in_action_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_row_select_i,
  input  logic [23:0] out_column_bits_i,
  input  logic [8:0]  out_tick_period_i
);
  import lmps_pkg::*;

  // An accepted tick always yields a result on the next cycle
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_TICK) |=> out_valid_i)
    else $error("tick accepted without a result");

  // The shown row is a single row
  a_row_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot(out_row_select_i))
    else $error("row_select not one-hot");

  // Period is one of the three timer values
  a_period_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_tick_period_i == PERIOD_SHORT) ||
                    (out_tick_period_i == PERIOD_MID) ||
                    (out_tick_period_i == PERIOD_LONG))
    else $error("illegal tick period");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_column_bits_i) &&
                                    $stable(out_row_select_i))
    else $error("stalled result changed");

endmodule

bind led_matrix_pwm_scanner lmps_checker u_lmps_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_action_i       (in_i.action),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_row_select_i  (out_o.row_select),
  .out_column_bits_i (out_o.column_bits),
  .out_tick_period_i (out_o.tick_period)
);

// File: tb/sv/led_matrix_pwm_scanner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_matrix_pwm_scanner_test: self-checking bench for the PWM row scanner
// Requests are fed from a queue by a clocked driver. A clocked monitor keeps a
// cycle-free copy of the scanner state that predicts every scan tick result
// and compares each result field by field. Directed corner requests come
// first, then random frame loads, tick runs, state sets and ignored requests
// under three handshake stall profiles.
// ----------------------------------------------------------------------------
module led_matrix_pwm_scanner_test;
  import lmps_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         PLANE_BYTES = 32;
  localparam int         MAX_REPORTS = 10;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [1:0] SEL_NONE = 2'(BUFFERS);

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] buffer_sel;
    logic [6:0] byte_addr;
    logic [7:0] byte_data;
    logic [1:0] new_state;
  } scan_req_t;

  typedef struct packed {
    logic [7:0]  row_select;
    logic [23:0] column_bits;
    logic [8:0]  tick_period;
    logic [1:0]  shown_buffer;
    logic        frame_done;
    logic [5:0]  buffer_states;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lmps_in_if  req_if ();
  lmps_out_if res_if ();
  lmps_cfg_if cfg_if ();

  led_matrix_pwm_scanner u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pending requests and predicted tick results
  scan_req_t    req_queue[$];
  scan_result_t expected_scans[$];
  logic         req_taken = 1'b0;
  int           send_idle_pct = 16;
  int           recv_idle_pct = 49;
  int           mismatches = 0;
  int           results_seen = 0;
  int           cycle_cnt = 0;

  // Shadow of the scanner state
  logic [ROW_W-1:0] scan_row = '0;
  logic [LVL_W-1:0] bright_lvl = '0;
  logic [FC_W-1:0]  frame_cnt = '0;
  logic [1:0]       cur_buf = 2'd0;
  logic [1:0]       next_buf = 2'd1;
  logic [1:0]       buf_st [BUFFERS];
  logic [7:0]       pix_mem [MEM_DEPTH];
  logic [23:0]      pend_cols = '0;
  logic [8:0]       period_reg = PERIOD_MID;
  logic             auto_adv = 1'b1;

  function automatic logic [1:0] following_buf(input logic [1:0] b);
    return (int'(b) >= BUFFERS - 1) ? 2'd0 : b + 2'd1;
  endfunction

  // Update the shadow state for one accepted request; ticks queue a result
  function automatic void apply_request(input scan_req_t r);
    scan_result_t res;
    int           row_n, lvl_n, fc_n, c, k, n;
    logic [7:0]   b;
    logic [23:0]  cols;
    case (r.action)
      ACT_WRITE: begin
        if (int'(r.buffer_sel) < BUFFERS && int'(r.byte_addr) < BUF_BYTES)
          pix_mem[int'(r.buffer_sel) * BUF_BYTES + int'(r.byte_addr)] = r.byte_data;
      end
      ACT_STATE: begin
        if (int'(r.buffer_sel) < BUFFERS) buf_st[r.buffer_sel] = r.new_state;
      end
      ACT_TICK: begin
        res.row_select = 8'd1 << scan_row;
        res.column_bits = pend_cols;
        // interlaced row order, level steps after each full pass
        row_n = int'(scan_row) + 2;
        if (row_n == ROWS) row_n = 1;
        if (row_n > ROWS) begin
          row_n = 0;
          lvl_n = int'(bright_lvl) + 1;
          if (lvl_n >= LEVELS) lvl_n = 0;
          bright_lvl = LVL_W'(lvl_n);
          if (bright_lvl < LVL_MID) period_reg = PERIOD_SHORT;
          else if (bright_lvl < LVL_LONG) period_reg = PERIOD_MID;
          else period_reg = PERIOD_LONG;
        end
        scan_row = ROW_W'(row_n);
        // frame end swaps buffers
        res.frame_done = 1'b0;
        fc_n = int'(frame_cnt) + 1;
        if (fc_n >= FRAME_TICKS) begin
          fc_n = 0;
          res.frame_done = 1'b1;
          buf_st[cur_buf] = ST_CLEAN;
          buf_st[next_buf] = ST_BUSY;
          cur_buf = next_buf;
        end
        frame_cnt = FC_W'(fc_n);
        // green, red, blue; high nibble first
        cols = '0;
        for (c = 0; c < 3; c++) begin
          for (k = 0; k < 4; k++) begin
            b = pix_mem[int'(cur_buf) * BUF_BYTES + c * PLANE_BYTES + int'(scan_row) * 4 + k];
            cols = {cols[21:0], b[7:4] > bright_lvl, b[3:0] > bright_lvl};
          end
        end
        pend_cols = cols;
        for (c = 0; c < BUFFERS; c++)
          if (buf_st[c] == ST_CMD) buf_st[c] = ST_CLEAN;
        // look for the next buffer holding a frame
        if (auto_adv && next_buf == cur_buf) begin
          next_buf = following_buf(next_buf);
          n = 0;
          while (n < BUFFERS && next_buf != cur_buf && buf_st[next_buf] != ST_FRAME) begin
            next_buf = following_buf(next_buf);
            n++;
          end
        end
        res.tick_period = period_reg;
        res.shown_buffer = cur_buf;
        res.buffer_states = '0;
        for (c = 0; c < BUFFERS; c++) res.buffer_states[2 * c +: 2] = buf_st[c];
        expected_scans.push_back(res);
      end
      default: ;
    endcase
  endfunction

  function automatic scan_req_t mk_req(input logic [1:0] act, input logic [1:0] sel,
                                       input logic [6:0] addr, input logic [7:0] data,
                                       input logic [1:0] st);
    scan_req_t r;
    r.action = act;
    r.buffer_sel = sel;
    r.byte_addr = addr;
    r.byte_data = data;
    r.new_state = st;
    return r;
  endfunction

  // Request driver: changes on the falling edge
  always @(negedge clk) begin
    scan_req_t r;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        r = req_queue.pop_front();
        req_if.valid <= 1'b1;
        req_if.action <= r.action;
        req_if.buffer_sel <= r.buffer_sel;
        req_if.byte_addr <= r.byte_addr;
        req_if.byte_data <= r.byte_data;
        req_if.new_state <= r.new_state;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls
  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: check results, then predict accepted requests
  always @(posedge clk) begin
    scan_result_t got, want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        got.row_select = res_if.row_select;
        got.column_bits = res_if.column_bits;
        got.tick_period = res_if.tick_period;
        got.shown_buffer = res_if.shown_buffer;
        got.frame_done = res_if.frame_done;
        got.buffer_states = res_if.buffer_states;
        if (expected_scans.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d arrived with nothing expected: row=%h cols=%h",
                     results_seen, got.row_select, got.column_bits);
        end else begin
          want = expected_scans.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"result %0d differs: exp row=%h cols=%h per=%0d buf=%0d done=%b",
                        " st=%h / got row=%h cols=%h per=%0d buf=%0d done=%b st=%h"},
                       results_seen, want.row_select, want.column_bits, want.tick_period,
                       want.shown_buffer, want.frame_done, want.buffer_states,
                       got.row_select, got.column_bits, got.tick_period,
                       got.shown_buffer, got.frame_done, got.buffer_states);
          end
        end
        results_seen++;
      end
      if (req_if.valid && req_if.ready)
        apply_request(mk_req(req_if.action, req_if.buffer_sel, req_if.byte_addr,
                             req_if.byte_data, req_if.new_state));
    end
    req_taken <= rst_n && req_if.valid && req_if.ready;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Wait until every request is in and every tick result is out
  task automatic wait_drained();
    while (req_queue.size() != 0 || req_if.valid || expected_scans.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_auto_next(input logic v);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    auto_adv = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic: mostly frame loads and tick runs, some state sets and noise
  task automatic queue_random_items(input int target);
    int counted, kind, n, sel;
    counted = 0;
    while (counted < target) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        n = $urandom_range(48, 8);
        repeat (n)
          req_queue.push_back(mk_req(ACT_TICK, 2'($urandom), 7'($urandom), 8'($urandom),
                                     2'($urandom)));
        counted += n;
      end else if (kind < 75) begin
        sel = $urandom_range(BUFFERS - 1);
        n = $urandom_range(16, 4);
        repeat (n)
          req_queue.push_back(mk_req(ACT_WRITE, 2'(sel), 7'($urandom_range(BUF_BYTES - 1)),
                                     8'($urandom), 2'($urandom)));
        counted += n;
        if ($urandom_range(9) < 8) begin
          req_queue.push_back(mk_req(ACT_STATE, 2'(sel), 7'($urandom), 8'($urandom),
                                     ST_FRAME));
          counted++;
        end
      end else if (kind < 90) begin
        req_queue.push_back(mk_req(ACT_STATE, 2'($urandom_range(BUFFERS - 1)), 7'($urandom),
                                   8'($urandom), 2'($urandom)));
        counted++;
      end else begin
        // requests the block must ignore
        case ($urandom_range(3))
          0: req_queue.push_back(mk_req(ACT_NONE, 2'($urandom), 7'($urandom), 8'($urandom),
                                        2'($urandom)));
          1: req_queue.push_back(mk_req(ACT_WRITE, SEL_NONE, 7'($urandom), 8'($urandom),
                                        2'($urandom)));
          2: req_queue.push_back(mk_req(ACT_WRITE, 2'($urandom_range(BUFFERS - 1)),
                                        7'($urandom_range(127, BUF_BYTES)), 8'($urandom),
                                        2'($urandom)));
          default: req_queue.push_back(mk_req(ACT_STATE, SEL_NONE, 7'($urandom),
                                              8'($urandom), 2'($urandom)));
        endcase
      end
    end
  endtask

  initial begin
    int i, ph;
    req_if.valid = 1'b0;
    req_if.action = ACT_TICK;
    req_if.buffer_sel = '0;
    req_if.byte_addr = '0;
    req_if.byte_data = '0;
    req_if.new_state = ST_CLEAN;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = 1'b0;
    for (i = 0; i < MEM_DEPTH; i++) pix_mem[i] = '0;
    for (i = 0; i < BUFFERS; i++) buf_st[i] = ST_FRAME;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_auto_next(1'b1);

    // Directed: byte and nibble extremes, ignored requests, command clear
    req_queue.push_back(mk_req(ACT_WRITE, 2'd0, 7'd0, 8'hff, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_WRITE, 2'd0, 7'd1, 8'h0f, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_WRITE, 2'd0, 7'd2, 8'h00, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_WRITE, 2'd0, 7'd95, 8'hf0, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_WRITE, 2'd1, 7'd32, 8'hff, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_WRITE, 2'd2, 7'd95, 8'hff, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_WRITE, SEL_NONE, 7'd0, 8'hff, ST_CMD));
    req_queue.push_back(mk_req(ACT_WRITE, 2'd0, 7'd96, 8'haa, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_WRITE, 2'd0, 7'd127, 8'h55, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_STATE, SEL_NONE, 7'd0, 8'h00, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_NONE, 2'd3, 7'd127, 8'hff, ST_CMD));
    req_queue.push_back(mk_req(ACT_STATE, 2'd1, 7'd0, 8'h00, ST_CMD));
    req_queue.push_back(mk_req(ACT_STATE, 2'd2, 7'd0, 8'h00, ST_BUSY));
    repeat (8) req_queue.push_back(mk_req(ACT_TICK, 2'd0, 7'd0, 8'h00, ST_CLEAN));
    req_queue.push_back(mk_req(ACT_STATE, 2'd2, 7'd0, 8'h00, ST_FRAME));
    req_queue.push_back(mk_req(ACT_STATE, 2'd1, 7'd0, 8'h00, ST_CLEAN));
    repeat (2) req_queue.push_back(mk_req(ACT_TICK, 2'd3, 7'd127, 8'hff, ST_CMD));
    wait_drained();

    // Random phases; each pauses half way until all results are back
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 16 : 0;
      write_auto_next((ph == 1) ? 1'b0 : 1'b1);
      queue_random_items(280);
      wait_drained();
      write_auto_next(1'($urandom_range(1)));
      queue_random_items(280);
      wait_drained();
    end

    mismatches += expected_scans.size();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
